@@ rtl/sis_pkg.sv @@
// Shared types and constants for the sorted interval set core.
// Used by sis_engine and sorted_interval_set_core; no dependencies.
package sis_pkg;

  localparam int MAX_RUNS  = 64;
  localparam int ADDR_W    = $clog2(MAX_RUNS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int NUM_W     = 31;
  localparam int SKIP_SPAN = 10;
  localparam int ACC_W     = NUM_W + CNT_W + 2;

  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_ADD   = 3'd1;
  localparam logic [2:0] REQ_QUERY = 3'd2;
  localparam logic [2:0] REQ_COUNT = 3'd3;
  localparam logic [2:0] REQ_NEXT  = 3'd4;

  localparam logic [1:0] CFG_AVAIL_LOW   = 2'd0;
  localparam logic [1:0] CFG_AVAIL_HIGH  = 2'd1;
  localparam logic [1:0] CFG_AVAIL_VALID = 2'd2;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [NUM_W-1:0] run_start;
    logic [NUM_W-1:0] run_end;
    logic [NUM_W-1:0] query_number;
    logic [NUM_W-1:0] lower_limit;
    logic             skip_short;
    logic             single_only;
  } req_t;

  typedef struct packed {
    logic             member;
    logic [31:0]      unread_total;
    logic             found;
    logic [NUM_W-1:0] gap_start;
    logic [NUM_W-1:0] gap_end;
    logic [31:0]      gap_length;
    logic [NUM_W-1:0] new_lower_limit;
    logic             table_full;
  } rsp_t;

  typedef struct packed {
    logic [NUM_W-1:0] avail_low;
    logic [NUM_W-1:0] avail_high;
    logic             avail_valid;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] low;
    logic [NUM_W-1:0] high;
  } run_t;

endpackage

@@ rtl/sis_engine.sv @@
// Run table and the sequencer that walks it one entry at a time.
// Depends on sis_pkg.
module sis_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sis_pkg::req_t req,
  input  sis_pkg::cfg_t cfg,
  output logic          busy,
  output logic          rsp_valid,
  input  logic          rsp_take,
  output sis_pkg::rsp_t rsp
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_EV   = 7'b0000100,
    S_FIN  = 7'b0001000,
    S_SHRD = 7'b0010000,
    S_SHWR = 7'b0100000,
    S_INS  = 7'b1000000
  } state_t;

  localparam int NW = sis_pkg::NUM_W;
  localparam int CW = sis_pkg::CNT_W;
  localparam int AW = sis_pkg::ACC_W;

  state_t state;
  logic   done;

  sis_pkg::run_t mem [sis_pkg::MAX_RUNS];
  sis_pkg::run_t rd_q;
  sis_pkg::run_t wd;
  logic [sis_pkg::ADDR_W-1:0] ra, wa;
  logic we;

  sis_pkg::req_t r;
  logic [CW-1:0] n, idx, i_pos, k, d;
  logic ph2, hit, up;
  logic [NW-1:0] lo, hi, m_lo, m_hi;
  logic signed [AW-1:0] acc;
  logic [31:0] from_r, to_r;

  logic [NW-1:0] amin, amax;
  logic [32:0] nl;
  logic [31:0] c_low;
  logic keep;

  assign amin = (cfg.avail_low < cfg.avail_high) ? cfg.avail_low : cfg.avail_high;
  assign amax = (cfg.avail_low < cfg.avail_high) ? cfg.avail_high : cfg.avail_low;

  assign busy      = (state != S_IDLE) || done;
  assign rsp_valid = done;

  assign c_low = {1'b0, rd_q.low} - 32'd1;
  assign keep  = !r.skip_short ||
                 ((rd_q.high - rd_q.low) >= NW'(sis_pkg::SKIP_SPAN)) ||
                 (({1'b0, rd_q.low} <= from_r) && ({1'b0, rd_q.high} >= to_r));
  assign nl = ((to_r <= from_r) || r.single_only) ? ({1'b0, from_r} + 33'd1)
                                                  : ({1'b0, to_r} + 33'd1);

  always_comb begin
    ra = idx[sis_pkg::ADDR_W-1:0];
    we = 1'b0;
    wa = i_pos[sis_pkg::ADDR_W-1:0];
    wd = hit ? {m_lo, m_hi} : {lo, hi};
    case (state)
      S_SHRD: ra = up ? (k[sis_pkg::ADDR_W-1:0] - 1'b1) : k[sis_pkg::ADDR_W-1:0];
      S_SHWR: begin
        we = 1'b1;
        wa = up ? k[sis_pkg::ADDR_W-1:0] : (k[sis_pkg::ADDR_W-1:0] - d[sis_pkg::ADDR_W-1:0]);
        wd = rd_q;
      end
      S_INS:  we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      n     <= '0;
    end else begin
      if (done && rsp_take) begin
        done <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            r     <= req;
            rsp   <= '0;
            idx   <= '0;
            i_pos <= '0;
            ph2   <= 1'b0;
            hit   <= 1'b0;
            lo    <= (req.run_start < req.run_end) ? req.run_start : req.run_end;
            hi    <= (req.run_start < req.run_end) ? req.run_end : req.run_start;
            acc   <= AW'({1'b0, amax}) - AW'({1'b0, amin}) + AW'(1);
            from_r <= (req.lower_limit > amin) ? {1'b0, req.lower_limit} : {1'b0, amin};
            to_r   <= {1'b0, amax};
            case (req.req_type)
              sis_pkg::REQ_CLEAR: begin
                n    <= '0;
                done <= 1'b1;
              end
              sis_pkg::REQ_ADD, sis_pkg::REQ_QUERY: state <= S_RD;
              sis_pkg::REQ_COUNT: begin
                if (cfg.avail_valid) begin
                  state <= S_RD;
                end else begin
                  done <= 1'b1;
                end
              end
              sis_pkg::REQ_NEXT: begin
                rsp.new_lower_limit <= req.lower_limit;
                if (cfg.avail_valid && (req.lower_limit <= amax)) begin
                  state <= S_RD;
                end else begin
                  done <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_RD: state <= (idx < n) ? S_EV : S_FIN;
        S_EV: begin
          state <= S_RD;
          idx   <= idx + 1'b1;
          case (r.req_type)
            sis_pkg::REQ_ADD: begin
              if (!ph2 && (({1'b0, rd_q.high} + 32'd1) < {1'b0, lo})) begin
                i_pos <= idx + 1'b1;
              end else begin
                ph2 <= 1'b1;
                if ({1'b0, rd_q.low} <= ({1'b0, hi} + 32'd1)) begin
                  hit <= 1'b1;
                  if (!hit) begin
                    m_lo <= (rd_q.low < lo) ? rd_q.low : lo;
                  end
                  m_hi <= (rd_q.high > hi) ? rd_q.high : hi;
                end else begin
                  idx   <= idx;
                  state <= S_FIN;
                end
              end
            end
            sis_pkg::REQ_QUERY: begin
              if ((rd_q.low <= r.query_number) && (rd_q.high >= r.query_number)) begin
                rsp.member <= 1'b1;
                state      <= S_FIN;
              end else if (rd_q.low > r.query_number) begin
                state <= S_FIN;
              end
            end
            sis_pkg::REQ_COUNT: begin
              acc <= acc - (AW'({1'b0, rd_q.high}) - AW'({1'b0, rd_q.low}) + AW'(1));
            end
            default: begin
              if (ph2 || ({1'b0, rd_q.high} >= from_r)) begin
                ph2 <= 1'b1;
                if ({1'b0, rd_q.low} <= to_r) begin
                  if (keep) begin
                    if ({1'b0, rd_q.low} <= from_r) begin
                      from_r <= {1'b0, rd_q.high} + 32'd1;
                    end else begin
                      to_r  <= (c_low > from_r) ? c_low : from_r;
                      state <= S_FIN;
                    end
                  end
                end else begin
                  state <= S_FIN;
                end
              end
            end
          endcase
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
          case (r.req_type)
            sis_pkg::REQ_COUNT: begin
              rsp.unread_total <= (acc > 0) ? acc[31:0] : 32'd0;
            end
            sis_pkg::REQ_NEXT: begin
              if (from_r <= {1'b0, amax}) begin
                rsp.found      <= 1'b1;
                rsp.gap_start  <= from_r[NW-1:0];
                rsp.gap_end    <= to_r[NW-1:0];
                rsp.gap_length <= to_r - from_r + 32'd1;
                rsp.new_lower_limit <= nl[32:31] != 2'b00 ? {NW{1'b1}} : nl[NW-1:0];
              end
            end
            sis_pkg::REQ_ADD: begin
              if (!hit && (n >= CW'(sis_pkg::MAX_RUNS))) begin
                rsp.table_full <= 1'b1;
              end else begin
                // idx now marks the first entry past the merged block
                done  <= 1'b0;
                state <= S_SHRD;
                up    <= !hit;
                k     <= hit ? idx : n;
                d     <= idx - i_pos - 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_SHRD: begin
          if (up ? (k > i_pos) : (k < n)) begin
            state <= S_SHWR;
          end else begin
            state <= S_INS;
          end
        end
        S_SHWR: begin
          k     <= up ? (k - 1'b1) : (k + 1'b1);
          state <= S_SHRD;
        end
        S_INS: begin
          n     <= hit ? (n - d) : (n + 1'b1);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CW'(sis_pkg::MAX_RUNS))
    else $error("run count beyond table depth");
  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV) |-> $past(state) == S_RD)
    else $error("entry evaluated without a read");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !done)
    else $error("result pending while sequencer runs");
  a_count_changes: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHRD || state == S_SHWR) |=> $stable(n))
    else $error("run count changed during shift");
`endif

endmodule

@@ rtl/sorted_interval_set_core.sv @@
// Top level of the sorted interval set core: config registers, output register.
// Depends on sis_pkg and sis_engine.

// Keeps up to 64 sorted, disjoint inclusive runs and serves clear, add, query,
// unread count and next-unread requests, one transaction at a time. A request
// walks the stored runs through the run table, reading and then evaluating
// each entry visited; an add that inserts or merges also moves the entries
// above the merge point, reading and then writing each one. A finished
// result sits in an output register, and the next request is taken while it
// waits. Configuration writes are always ready.
module sorted_interval_set_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sis_pkg::req_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sis_pkg::rsp_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [sis_pkg::NUM_W-1:0]      cfg_data
);

  sis_pkg::cfg_t cfg;
  sis_pkg::rsp_t rsp;
  logic busy, rsp_valid, load;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign load      = rsp_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sis_pkg::CFG_AVAIL_LOW:   cfg.avail_low   <= cfg_data;
        sis_pkg::CFG_AVAIL_HIGH:  cfg.avail_high  <= cfg_data;
        sis_pkg::CFG_AVAIL_VALID: cfg.avail_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sis_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && !in_stall),
    .req       (in_data),
    .cfg       (cfg),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp_take  (load),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= rsp;
    end
  end

endmodule
